/* rtl/bbs_pkg.sv */
// shared types, constants and the channel blend function of the bilinear scaler
// no dependencies; every other file refers to it by scoped names
package bbs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int COORD_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int PIX_W    = 32;
  localparam int FRAC_SH  = 16;
  localparam int FRAC_W   = 8;
  localparam int STEP_W   = SIZE_W + FRAC_SH;
  localparam int POS_W    = COORD_W + STEP_W;
  localparam int INT_W    = POS_W - FRAC_SH;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = PIX_W / CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [SIZE_W-1:0] SIZE_RST   = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(65536);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(STEP_W);

  typedef enum logic [0:0] {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_TGT_W = 3'd2,
    REG_TGT_H = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_COL,
    DIV_ROW
  } div_state_e;

  typedef enum logic [1:0] {
    JOB_STORE,
    JOB_ERR,
    JOB_PIXEL
  } job_kind_e;

  typedef enum logic [1:0] {
    PH_P00 = 2'd0,
    PH_P01 = 2'd1,
    PH_P10 = 2'd2,
    PH_P11 = 2'd3
  } phase_e;

  typedef struct packed {
    logic                op;
    logic [COORD_W-1:0]  source_col;
    logic [COORD_W-1:0]  source_row;
    logic [PIX_W-1:0]    source_pixel;
    logic [COORD_W-1:0]  target_col;
    logic [COORD_W-1:0]  target_row;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] scaled_pixel;
    logic             coord_error;
  } out_t;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] row_step;
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] tgt_w;
    logic [SIZE_W-1:0] tgt_h;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    logic [COL_W-1:0]  col0;
    logic [ROW_W-1:0]  row0;
    logic [COL_W-1:0]  col1;
    logic [ROW_W-1:0]  row1;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [PIX_W-1:0]  pixel;
  } job_t;

  function automatic logic [ADDR_W-1:0] make_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    return ADDR_W'(int'(row) * MAX_WIDTH + int'(col));
  endfunction

  // a + floor((b - a) * f / 256) with an arithmetic shift doing the floor
  function automatic logic [CH_W-1:0] blend8(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                             logic [FRAC_W-1:0] f);
    logic signed [CH_W:0]       diff;
    logic signed [CH_W+FRAC_W+1:0] prod;
    logic signed [CH_W+FRAC_W+1:0] quo;
    logic signed [CH_W+1:0]     sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = (CH_W+FRAC_W+2)'(diff) * (CH_W+FRAC_W+2)'($signed({1'b0, f}));
    quo  = prod >>> FRAC_W;
    sum  = $signed({2'b00, a}) + quo[CH_W+1:0];
    return sum[CH_W-1:0];
  endfunction

endpackage

/* rtl/bgra_bilinear_scaler.sv */
// Bilinear BGRA scaler over a single-ported source frame store.
// Input channel (in_valid_i/in_ready_o/in_data_i): op store writes source_pixel
// at (source_col, source_row) and gives no result; op compute returns one beat
// on the output channel with the interpolated pixel, or zero with coord_error
// set when the destination coordinate lies outside the target size.
// Config port: cfg_we_i writes register cfg_idx_i (0 source width, 1 source
// height, 2 target width, 3 target height); each write reruns a bit-serial
// divider for both 11.16 steps while in_ready_o stays low.
// A compute beat holds the one frame store port for its four neighbor reads;
// a store beat makes a single write and an out-of-range beat makes no access.
// A compute beat passes the front-end register, the job queue, the read stage with
// its four reads, the blend stage and the output register; errors skip the reads.
// A four-entry job queue sits between the front and back end, so beats keep
// being accepted while the receiver stalls until that queue fills.
// Reset clears control state and sets all sizes to 1024 and the steps to 1.0;
// frame store contents are undefined until written.
// depends on bbs_pkg, bbs_cfg, bbs_front, bbs_fifo, bbs_back
module bgra_bilinear_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bbs_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bbs_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbs_pkg::SIZE_W-1:0]    cfg_data_i
);

  bbs_pkg::cfg_t cfg;
  bbs_pkg::job_t push_job, pop_job;
  logic push, full, pop, job_valid;

  bbs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  bbs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .pop_job_o  (pop_job)
  );

  bbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/bbs_cfg.sv */
// size registers and the shared bit-serial divider that derives the 11.16 steps
// depends on bbs_pkg
module bbs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbs_pkg::SIZE_W-1:0]     cfg_data_i,
  output bbs_pkg::cfg_t                  cfg_o
);

  logic [bbs_pkg::SIZE_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [bbs_pkg::SIZE_W-1:0] sw, sh;
  logic [bbs_pkg::STEP_W-1:0] col_step_q, row_step_q;
  logic [bbs_pkg::STEP_W-1:0] num_q, quo_q, quo_d;
  logic [bbs_pkg::SIZE_W-1:0] den_q;
  logic [bbs_pkg::SIZE_W:0]   rem_q, rem_d, rem_sh;
  logic [bbs_pkg::DIV_CNT_W-1:0] cnt_q;
  bbs_pkg::div_state_e state_q, state_d;
  logic hit, active, load, finish;

  assign hit = cfg_we_i && (cfg_idx_i == bbs_pkg::REG_SRC_W || cfg_idx_i == bbs_pkg::REG_SRC_H ||
                            cfg_idx_i == bbs_pkg::REG_TGT_W || cfg_idx_i == bbs_pkg::REG_TGT_H);

  always_comb begin
    sw = src_w_q;
    if (src_w_q == '0) begin
      sw = bbs_pkg::SIZE_W'(1);
    end else if (src_w_q > bbs_pkg::MAX_W_SIZE) begin
      sw = bbs_pkg::MAX_W_SIZE;
    end
    sh = src_h_q;
    if (src_h_q == '0) begin
      sh = bbs_pkg::SIZE_W'(1);
    end else if (src_h_q > bbs_pkg::MAX_H_SIZE) begin
      sh = bbs_pkg::MAX_H_SIZE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= bbs_pkg::SIZE_RST;
      src_h_q <= bbs_pkg::SIZE_RST;
      tgt_w_q <= bbs_pkg::SIZE_RST;
      tgt_h_q <= bbs_pkg::SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbs_pkg::REG_SRC_W: src_w_q <= cfg_data_i;
        bbs_pkg::REG_SRC_H: src_h_q <= cfg_data_i;
        bbs_pkg::REG_TGT_W: tgt_w_q <= cfg_data_i;
        bbs_pkg::REG_TGT_H: tgt_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbs_pkg::DIV_IDLE: if (hit) state_d = bbs_pkg::DIV_COL;
      bbs_pkg::DIV_COL: begin
        if (hit) state_d = bbs_pkg::DIV_COL;
        else if (cnt_q == bbs_pkg::DIV_LAST) state_d = bbs_pkg::DIV_ROW;
      end
      bbs_pkg::DIV_ROW: begin
        if (hit) state_d = bbs_pkg::DIV_COL;
        else if (cnt_q == bbs_pkg::DIV_LAST) state_d = bbs_pkg::DIV_IDLE;
      end
      default: state_d = bbs_pkg::DIV_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    active = 1'b0;
    load   = 1'b0;
    finish = 1'b0;
    case (state_q)
      bbs_pkg::DIV_COL, bbs_pkg::DIV_ROW: begin
        active = !hit;
        load   = !hit && cnt_q == '0;
        finish = !hit && cnt_q == bbs_pkg::DIV_LAST;
      end
      default: ;
    endcase
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[bbs_pkg::SIZE_W-1:0], num_q[bbs_pkg::STEP_W-1]};
    rem_d  = rem_sh;
    quo_d  = {quo_q[bbs_pkg::STEP_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_d  = rem_sh - {1'b0, den_q};
      quo_d  = {quo_q[bbs_pkg::STEP_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bbs_pkg::DIV_IDLE;
      cnt_q      <= '0;
      col_step_q <= bbs_pkg::STEP_RST;
      row_step_q <= bbs_pkg::STEP_RST;
    end else begin
      state_q <= state_d;
      if (hit || finish) begin
        cnt_q <= '0;
      end else if (active) begin
        cnt_q <= cnt_q + bbs_pkg::DIV_CNT_W'(1);
      end
      if (finish && state_q == bbs_pkg::DIV_COL) begin
        col_step_q <= (den_q == '0) ? '0 : quo_d;
      end
      if (finish && state_q == bbs_pkg::DIV_ROW) begin
        row_step_q <= (den_q == '0) ? '0 : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= '0;
      quo_q <= '0;
      if (state_q == bbs_pkg::DIV_COL) begin
        num_q <= {sw, {bbs_pkg::FRAC_SH{1'b0}}};
        den_q <= tgt_w_q;
      end else begin
        num_q <= {sh, {bbs_pkg::FRAC_SH{1'b0}}};
        den_q <= tgt_h_q;
      end
    end else if (active) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      num_q <= {num_q[bbs_pkg::STEP_W-2:0], 1'b0};
    end
  end

  assign cfg_o.busy     = state_q != bbs_pkg::DIV_IDLE;
  assign cfg_o.col_step = col_step_q;
  assign cfg_o.row_step = row_step_q;
  assign cfg_o.src_w    = sw;
  assign cfg_o.src_h    = sh;
  assign cfg_o.tgt_w    = tgt_w_q;
  assign cfg_o.tgt_h    = tgt_h_q;

endmodule

/* rtl/bbs_front.sv */
// front end: accepts beats, maps destination coordinates to source neighbors
// and pushes store, error or pixel jobs, dropping stores outside the frame store; depends on bbs_pkg
module bbs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bbs_pkg::in_t   in_data_i,
  input  bbs_pkg::cfg_t  cfg_i,
  input  logic           full_i,
  output logic           push_o,
  output bbs_pkg::job_t  push_job_o
);

  logic                       a_valid_q;
  bbs_pkg::in_t               a_data_q;
  logic                       a_err_q;
  logic [bbs_pkg::POS_W-1:0]  a_px_q, a_py_q;
  logic [bbs_pkg::POS_W-1:0]  px_d, py_d;
  logic                       err_d, accept, drop, leave, is_compute;
  logic [bbs_pkg::INT_W-1:0]  sx_full, sy_full;
  logic [bbs_pkg::SIZE_W-1:0] sx_lim, sy_lim, sx_c, sy_c, sx_n, sy_n;

  assign px_d = {{(bbs_pkg::POS_W-bbs_pkg::COORD_W){1'b0}}, in_data_i.target_col}
              * {{bbs_pkg::COORD_W{1'b0}}, cfg_i.col_step};
  assign py_d = {{(bbs_pkg::POS_W-bbs_pkg::COORD_W){1'b0}}, in_data_i.target_row}
              * {{bbs_pkg::COORD_W{1'b0}}, cfg_i.row_step};
  assign err_d = {1'b0, in_data_i.target_col} >= cfg_i.tgt_w ||
                 {1'b0, in_data_i.target_row} >= cfg_i.tgt_h;

  assign is_compute = a_data_q.op == bbs_pkg::OP_COMPUTE;
  assign drop  = a_valid_q && !is_compute &&
                 (int'(a_data_q.source_col) >= bbs_pkg::MAX_WIDTH ||
                  int'(a_data_q.source_row) >= bbs_pkg::MAX_HEIGHT);
  assign leave = a_valid_q && (drop || !full_i);
  assign push_o = a_valid_q && !drop && !full_i;

  assign in_ready_o = !cfg_i.busy && (!a_valid_q || leave);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (leave) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_data_q <= in_data_i;
      a_err_q  <= err_d;
      a_px_q   <= px_d;
      a_py_q   <= py_d;
    end
  end

  // clamp to the last column/row, next neighbor clamped the same way
  always_comb begin
    sx_full = a_px_q[bbs_pkg::POS_W-1:bbs_pkg::FRAC_SH];
    sy_full = a_py_q[bbs_pkg::POS_W-1:bbs_pkg::FRAC_SH];
    sx_lim  = cfg_i.src_w - bbs_pkg::SIZE_W'(1);
    sy_lim  = cfg_i.src_h - bbs_pkg::SIZE_W'(1);
    sx_c = (sx_full > {{(bbs_pkg::INT_W-bbs_pkg::SIZE_W){1'b0}}, sx_lim}) ?
           sx_lim : sx_full[bbs_pkg::SIZE_W-1:0];
    sy_c = (sy_full > {{(bbs_pkg::INT_W-bbs_pkg::SIZE_W){1'b0}}, sy_lim}) ?
           sy_lim : sy_full[bbs_pkg::SIZE_W-1:0];
    sx_n = ({1'b0, sx_c} + 12'd1 < {1'b0, sx_lim}) ? sx_c + bbs_pkg::SIZE_W'(1) : sx_lim;
    sy_n = ({1'b0, sy_c} + 12'd1 < {1'b0, sy_lim}) ? sy_c + bbs_pkg::SIZE_W'(1) : sy_lim;
  end

  always_comb begin
    push_job_o.pixel = a_data_q.source_pixel;
    push_job_o.fx    = a_px_q[bbs_pkg::FRAC_SH-1 -: bbs_pkg::FRAC_W];
    push_job_o.fy    = a_py_q[bbs_pkg::FRAC_SH-1 -: bbs_pkg::FRAC_W];
    push_job_o.col1  = sx_n[bbs_pkg::COL_W-1:0];
    push_job_o.row1  = sy_n[bbs_pkg::ROW_W-1:0];
    if (!is_compute) begin
      push_job_o.kind = bbs_pkg::JOB_STORE;
      push_job_o.col0 = bbs_pkg::COL_W'(a_data_q.source_col);
      push_job_o.row0 = bbs_pkg::ROW_W'(a_data_q.source_row);
    end else begin
      push_job_o.kind = a_err_q ? bbs_pkg::JOB_ERR : bbs_pkg::JOB_PIXEL;
      push_job_o.col0 = sx_c[bbs_pkg::COL_W-1:0];
      push_job_o.row0 = sy_c[bbs_pkg::ROW_W-1:0];
    end
  end

endmodule

/* rtl/bbs_fifo.sv */
// short job queue between front and back end
// depends on bbs_pkg
module bbs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bbs_pkg::job_t  push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bbs_pkg::job_t  pop_job_o
);

  bbs_pkg::job_t                 mem_q [bbs_pkg::FIFO_DEPTH];
  logic [bbs_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [bbs_pkg::FIFO_PTR_W:0]   cnt_q;
  logic                           do_pop;

  assign full_o    = cnt_q == (bbs_pkg::FIFO_PTR_W+1)'(bbs_pkg::FIFO_DEPTH);
  assign valid_o   = cnt_q != '0;
  assign pop_job_o = mem_q[rd_q];
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + bbs_pkg::FIFO_PTR_W'(1);
      if (do_pop) rd_q <= rd_q + bbs_pkg::FIFO_PTR_W'(1);
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + (bbs_pkg::FIFO_PTR_W+1)'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - (bbs_pkg::FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

endmodule

/* rtl/bbs_back.sv */
// back end: frame store, four-phase neighbor fetch, two blend stages, output register
// depends on bbs_pkg
module bbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  bbs_pkg::job_t  job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bbs_pkg::out_t  out_data_o
);

  logic [bbs_pkg::PIX_W-1:0] frame_mem [bbs_pkg::MAX_WIDTH * bbs_pkg::MAX_HEIGHT];
  logic [bbs_pkg::PIX_W-1:0] rdata_q;
  logic [bbs_pkg::ADDR_W-1:0] addr;
  logic mem_we, mem_re, adv, is_pixel, is_store;
  bbs_pkg::phase_e phase_q, phase_d;

  logic                      rd_valid_q, rd_last_q, rd_err_q;
  bbs_pkg::phase_e           rd_phase_q;
  logic [bbs_pkg::FRAC_W-1:0] rd_fx_q, rd_fy_q;
  logic [bbs_pkg::PIX_W-1:0] p00_q, p01_q, p10_q;

  logic                      b1_valid_q, b1_err_q;
  logic [bbs_pkg::FRAC_W-1:0] b1_fy_q;
  logic [bbs_pkg::NUM_CH-1:0][bbs_pkg::CH_W-1:0] top_d, bot_d, top_q, bot_q, res_d;

  logic          out_valid_q;
  bbs_pkg::out_t out_q;

  // whole back end moves only when the output register can take a beat
  assign adv      = !out_valid_q || out_ready_i;
  assign is_pixel = job_i.kind == bbs_pkg::JOB_PIXEL;
  assign is_store = job_i.kind == bbs_pkg::JOB_STORE;
  assign mem_we   = adv && job_valid_i && is_store;
  assign mem_re   = adv && job_valid_i && is_pixel;
  assign job_pop_o = adv && job_valid_i && (!is_pixel || phase_q == bbs_pkg::PH_P11);

  // next phase
  always_comb begin
    case (phase_q)
      bbs_pkg::PH_P00: phase_d = bbs_pkg::PH_P01;
      bbs_pkg::PH_P01: phase_d = bbs_pkg::PH_P10;
      bbs_pkg::PH_P10: phase_d = bbs_pkg::PH_P11;
      default:         phase_d = bbs_pkg::PH_P00;
    endcase
  end

  // neighbor address for the current phase
  always_comb begin
    case (phase_q)
      bbs_pkg::PH_P00: addr = bbs_pkg::make_addr(job_i.col0, job_i.row0);
      bbs_pkg::PH_P01: addr = bbs_pkg::make_addr(job_i.col1, job_i.row0);
      bbs_pkg::PH_P10: addr = bbs_pkg::make_addr(job_i.col0, job_i.row1);
      default:         addr = bbs_pkg::make_addr(job_i.col1, job_i.row1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) frame_mem[addr] <= job_i.pixel;
    if (mem_re) rdata_q <= frame_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bbs_pkg::PH_P00;
      rd_valid_q  <= 1'b0;
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (mem_re) phase_q <= phase_d;
      rd_valid_q  <= job_valid_i && !is_store;
      b1_valid_q  <= rd_valid_q && rd_last_q;
      out_valid_q <= b1_valid_q;
    end
  end

  always_comb begin
    for (int c = 0; c < bbs_pkg::NUM_CH; c++) begin
      top_d[c] = bbs_pkg::blend8(p00_q[c*bbs_pkg::CH_W +: bbs_pkg::CH_W],
                                 p01_q[c*bbs_pkg::CH_W +: bbs_pkg::CH_W], rd_fx_q);
      bot_d[c] = bbs_pkg::blend8(p10_q[c*bbs_pkg::CH_W +: bbs_pkg::CH_W],
                                 rdata_q[c*bbs_pkg::CH_W +: bbs_pkg::CH_W], rd_fx_q);
      res_d[c] = bbs_pkg::blend8(top_q[c], bot_q[c], b1_fy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_last_q  <= !is_pixel || phase_q == bbs_pkg::PH_P11;
      rd_err_q   <= !is_pixel;
      rd_phase_q <= phase_q;
      rd_fx_q    <= job_i.fx;
      rd_fy_q    <= job_i.fy;
      // neighbors arrive one per cycle while the back end advances, the last one feeds the blend directly
      if (rd_valid_q && !rd_last_q) begin
        case (rd_phase_q)
          bbs_pkg::PH_P00: p00_q <= rdata_q;
          bbs_pkg::PH_P01: p01_q <= rdata_q;
          default:         p10_q <= rdata_q;
        endcase
      end
      b1_err_q <= rd_err_q;
      b1_fy_q  <= rd_fy_q;
      top_q    <= top_d;
      bot_q    <= bot_d;
      out_q.coord_error  <= b1_err_q;
      out_q.scaled_pixel <= b1_err_q ? '0 : res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
